FILE: sv/sfir_pkg.sv
package sfir_pkg;

  // Default configuration of the filter.
  localparam int unsigned NtapDef       = 481;
  localparam int unsigned SampleBitsDef = 24;
  localparam int unsigned CoefBitsDef   = 24;

  // Width of the coefficient index field on the input word.
  localparam int unsigned CoefIndexBits = 8;

  // Item kinds carried in the mode bit.
  localparam logic ModeFilter = 1'b0;
  localparam logic ModeLoad   = 1'b1;

  // Per-cycle control handed from the sequencer to the multiply-accumulate
  // datapath. It travels with the read addresses issued in the same cycle.
  typedef struct packed {
    logic clr;     // start of a new filter run: clear the accumulator
    logic valid;   // a tap read is issued this cycle
    logic centre;  // this read is the centre tap (last of the run)
  } mac_ctl_t;

endpackage

FILE: sv/symmetric_fir_with_bypass.sv
// Channel   Direction  tdata (lowest bit up)                        tuser
// s_axis    in         sample_in, coef_index, coef_value, zero pad  mode, bypass
// m_axis    out        sample_out, zero pad                         clipped
//
// After reset both memories are swept to zero, one entry a cycle, with
// s_axis_tready held low. The sequencer walks the folded tap pairs one
// per cycle into a single multiply-accumulate. A finished result waits in
// the output register; a finishing filtered or bypassed sample stalls until
// that register is free. s_axis_tready is high only while idle, so a new
// word is taken only once the previous sample has been handed on.
module symmetric_fir_with_bypass #(
  parameter int unsigned NTAP        = sfir_pkg::NtapDef,
  parameter int unsigned SAMPLE_BITS = sfir_pkg::SampleBitsDef,
  parameter int unsigned COEF_BITS   = sfir_pkg::CoefBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Fields from bit 0: sample_in, coef_index, coef_value, zero fill.
  input  logic [((SAMPLE_BITS + sfir_pkg::CoefIndexBits + COEF_BITS + 7) / 8) * 8 - 1:0]
               s_axis_tdata,
  // Fields from bit 0: mode, bypass.
  input  logic [1:0] s_axis_tuser,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // Fields from bit 0: sample_out, zero fill.
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // Fields from bit 0: clipped.
  output logic [0:0] m_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready
);

  localparam int unsigned Half  = NTAP / 2;
  localparam int unsigned PtrW  = $clog2(NTAP);
  localparam int unsigned CoefW = $clog2(Half + 1);
  localparam int unsigned IdxW  = sfir_pkg::CoefIndexBits;
  localparam int unsigned OutW  = ((SAMPLE_BITS + 7) / 8) * 8;

  // Sequencer states.
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRun   = 3'd2;
  localparam logic [2:0] StBwait = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;
  localparam logic [2:0] StFinal = 3'd5;

  // Input word fields.
  logic                   in_mode, in_bypass;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [IdxW-1:0]        in_index;
  logic [COEF_BITS-1:0]   in_coef;

  assign in_mode   = s_axis_tuser[0];
  assign in_bypass = s_axis_tuser[1];
  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_index  = s_axis_tdata[SAMPLE_BITS+IdxW-1:SAMPLE_BITS];
  assign in_coef   = s_axis_tdata[SAMPLE_BITS+IdxW+COEF_BITS-1:SAMPLE_BITS+IdxW];

  logic [2:0]       state_q, state_d;
  logic [PtrW-1:0]  clr_q, clr_d;
  logic [PtrW-1:0]  head_q, head_d;
  logic [PtrW-1:0]  ptr_a_q, ptr_a_d, ptr_b_q, ptr_b_d;
  logic [CoefW-1:0] tap_q, tap_d;
  logic             bypass_q, bypass_d;

  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] out_data_q, out_data_d;
  logic                   out_clip_q, out_clip_d;

  logic accept, out_free;
  logic [PtrW-1:0] head_new, head_prev;
  logic [PtrW:0]   mid_sum;
  logic [PtrW-1:0] mid;

  // Memory ports.
  logic                   dl_we;
  logic [PtrW-1:0]        dl_waddr;
  logic [SAMPLE_BITS-1:0] dl_wdata, dl_rdata_a, dl_rdata_b;
  logic                   cf_we;
  logic [CoefW-1:0]       cf_waddr;
  logic [COEF_BITS-1:0]   cf_wdata, cf_rdata;

  sfir_pkg::mac_ctl_t     mac_ctl;
  logic                   mac_done, mac_clip;
  logic [SAMPLE_BITS-1:0] mac_result;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  // The head moves back one place per sample; the second pointer starts one
  // place further back, which is the mirrored partner of the newest sample.
  always_comb begin
    head_new  = (head_q == '0) ? PtrW'(NTAP - 1) : head_q - PtrW'(1);
    head_prev = (head_new == '0) ? PtrW'(NTAP - 1) : head_new - PtrW'(1);
    mid_sum   = {1'b0, head_new} + (PtrW + 1)'(Half);
    mid       = (mid_sum >= (PtrW + 1)'(NTAP)) ? PtrW'(mid_sum - (PtrW + 1)'(NTAP))
                                               : mid_sum[PtrW-1:0];
  end

  // Memory writes: the reset sweep, a new sample, or a coefficient load.
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = head_new;
    dl_wdata = in_sample;
    cf_we    = 1'b0;
    cf_waddr = in_index[CoefW-1:0];
    cf_wdata = in_coef;
    if (state_q == StClear) begin
      dl_we    = 1'b1;
      dl_waddr = clr_q;
      dl_wdata = '0;
      cf_we    = (clr_q <= PtrW'(Half));
      cf_waddr = clr_q[CoefW-1:0];
      cf_wdata = '0;
    end else if (accept) begin
      if (in_mode == sfir_pkg::ModeFilter) begin
        dl_we = 1'b1;
      end else begin
        cf_we = ({1'b0, in_index} <= (IdxW + 1)'(Half));
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    head_d   = head_q;
    ptr_a_d  = ptr_a_q;
    ptr_b_d  = ptr_b_q;
    tap_d    = tap_q;
    bypass_d = bypass_q;
    mac_ctl  = '0;

    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    out_clip_d  = out_clip_q;

    case (state_q)
      StClear: begin
        clr_d = clr_q + PtrW'(1);
        if (clr_q == PtrW'(NTAP - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept && in_mode == sfir_pkg::ModeFilter) begin
          head_d   = head_new;
          bypass_d = in_bypass;
          tap_d    = '0;
          if (in_bypass) begin
            ptr_a_d = mid;
            state_d = StBwait;
          end else begin
            ptr_a_d     = head_new;
            ptr_b_d     = head_prev;
            mac_ctl.clr = 1'b1;
            state_d     = StRun;
          end
        end
      end
      StRun: begin
        // One folded pair per cycle; the centre tap reads the middle sample
        // on both pointers and the datapath drops the second one.
        mac_ctl.valid  = 1'b1;
        mac_ctl.centre = (tap_q == CoefW'(Half));
        ptr_a_d = (ptr_a_q == PtrW'(NTAP - 1)) ? '0 : ptr_a_q + PtrW'(1);
        ptr_b_d = (ptr_b_q == '0) ? PtrW'(NTAP - 1) : ptr_b_q - PtrW'(1);
        tap_d   = tap_q + CoefW'(1);
        if (mac_ctl.centre) begin
          state_d = StDrain;
        end
      end
      StBwait: begin
        state_d = StFinal;
      end
      StDrain: begin
        if (mac_done) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = bypass_q ? dl_rdata_a : mac_result;
          out_clip_d  = bypass_q ? 1'b0 : mac_clip;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      head_q      <= '0;
      ptr_a_q     <= '0;
      ptr_b_q     <= '0;
      tap_q       <= '0;
      bypass_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      ptr_a_q     <= ptr_a_d;
      ptr_b_q     <= ptr_b_d;
      tap_q       <= tap_d;
      bypass_q    <= bypass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_clip_q <= out_clip_d;
  end

  // Two copies of the delay line, written together, give two sample reads a
  // cycle for the folded pair.
  sfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (NTAP)
  ) u_delay_a (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (ptr_a_q),
    .rdata_o (dl_rdata_a)
  );

  sfir_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (NTAP)
  ) u_delay_b (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (ptr_b_q),
    .rdata_o (dl_rdata_b)
  );

  sfir_ram #(
    .WIDTH (COEF_BITS),
    .DEPTH (Half + 1)
  ) u_coef (
    .clk_i   (clk_i),
    .we_i    (cf_we),
    .waddr_i (cf_waddr),
    .wdata_i (cf_wdata),
    .raddr_i (tap_q),
    .rdata_o (cf_rdata)
  );

  sfir_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mac_ctl),
    .tap_a_i   (dl_rdata_a),
    .tap_b_i   (dl_rdata_b),
    .coef_i    (cf_rdata),
    .done_o    (mac_done),
    .result_o  (mac_result),
    .clipped_o (mac_clip)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_data_q);
  assign m_axis_tuser  = out_clip_q;

endmodule

FILE: sv/sfir_ram.sv
module sfir_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 481
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sfir_mac.sv
module sfir_mac #(
  parameter int unsigned SAMPLE_BITS = sfir_pkg::SampleBitsDef,
  parameter int unsigned COEF_BITS   = sfir_pkg::CoefBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfir_pkg::mac_ctl_t     ctl_i,
  input  logic [SAMPLE_BITS-1:0] tap_a_i,
  input  logic [SAMPLE_BITS-1:0] tap_b_i,
  input  logic [COEF_BITS-1:0]   coef_i,
  output logic                   done_o,
  output logic [SAMPLE_BITS-1:0] result_o,
  output logic                   clipped_o
);

  // Pair sum is one bit wider than a sample; the product adds the coefficient
  // width; up to 256 terms need eight guard bits, plus one spare.
  localparam int unsigned SumW  = SAMPLE_BITS + 1;
  localparam int unsigned ProdW = SumW + COEF_BITS;
  localparam int unsigned AccW  = ProdW + 9;
  localparam int unsigned ShW   = AccW - COEF_BITS + 1;
  localparam logic [AccW-1:0] RndConst = AccW'(1) << (COEF_BITS - 2);

  // Stage tags: read data valid, pair summed, product formed.
  logic rd_v_q, rd_v_d, rd_last_q, rd_last_d;
  logic sum_v_q, sum_v_d, sum_last_q, sum_last_d;
  logic prod_v_q, prod_v_d, prod_last_q, prod_last_d;
  logic done_q, done_d;

  logic signed [SumW-1:0]      sum_q, sum_d;
  logic signed [COEF_BITS-1:0] coef_q, coef_d;
  logic signed [ProdW-1:0]     prod_q, prod_d;
  logic signed [AccW-1:0]      acc_q, acc_d;

  logic [SumW-1:0] ext_a, ext_b;
  logic [AccW-1:0] rnd;
  logic [ShW-1:0]  shifted;
  logic [ShW-SAMPLE_BITS:0] top_bits;
  logic in_range;

  always_comb begin
    rd_v_d    = ctl_i.valid;
    rd_last_d = ctl_i.centre;

    ext_a = {tap_a_i[SAMPLE_BITS-1], tap_a_i};
    ext_b = rd_last_q ? '0 : {tap_b_i[SAMPLE_BITS-1], tap_b_i};
    sum_d      = $signed(ext_a + ext_b);
    coef_d     = $signed(coef_i);
    sum_v_d    = rd_v_q;
    sum_last_d = rd_last_q;

    prod_d      = sum_q * coef_q;
    prod_v_d    = sum_v_q;
    prod_last_d = sum_last_q;

    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + AccW'(prod_q);
    end
    done_d = prod_v_q & prod_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      sum_v_q     <= 1'b0;
      sum_last_q  <= 1'b0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      done_q      <= 1'b0;
      acc_q       <= '0;
    end else begin
      rd_v_q      <= rd_v_d;
      rd_last_q   <= rd_last_d;
      sum_v_q     <= sum_v_d;
      sum_last_q  <= sum_last_d;
      prod_v_q    <= prod_v_d;
      prod_last_q <= prod_last_d;
      done_q      <= done_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    coef_q <= coef_d;
    prod_q <= prod_d;
  end

  // Round half up, drop the coefficient fraction bits, then saturate.
  always_comb begin
    rnd      = acc_q + RndConst;
    shifted  = rnd[AccW-1:COEF_BITS-1];
    top_bits = shifted[ShW-1:SAMPLE_BITS-1];
    in_range = (&top_bits) | ~(|top_bits);
    if (in_range) begin
      result_o = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[ShW-1]) begin
      result_o = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    clipped_o = ~in_range;
  end

  assign done_o = done_q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the folded symmetric FIR filter with bypass.
//
// Words go in on the slave stream and are mirrored into a local model of the
// filter: a circular delay line with its head, and the half-length table of
// coefficients. Every filter word (mode 0) leaves one expected output word on
// a queue. Coefficient loads (mode 1) only update the local table. A checker
// process compares each word taken from the master stream with the oldest
// expected word.
//
// Stimulus is a short directed run that hits the field extremes, ignored
// coefficient indices, bypass, saturation at both rails and rounding of a
// half. It is followed by randomised runs under different patterns of
// back-pressure and source gaps.
module testbench;

  localparam int Ntap        = sfir_pkg::NtapDef;
  localparam int Half        = Ntap / 2;
  localparam int SampleBits  = sfir_pkg::SampleBitsDef;
  localparam int CoefBits    = sfir_pkg::CoefBitsDef;
  localparam int IndexBits   = sfir_pkg::CoefIndexBits;
  localparam int InDataBits  = ((SampleBits + IndexBits + CoefBits + 7) / 8) * 8;
  localparam int OutDataBits = ((SampleBits + 7) / 8) * 8;

  // Saturation rails of the output sample.
  localparam longint SatMax = (longint'(1) <<< (SampleBits - 1)) - 1;
  localparam longint SatMin = -(longint'(1) <<< (SampleBits - 1));

  // One input word, split into its fields.
  typedef struct {
    logic                              mode;
    logic                              bypass;
    logic signed [SampleBits-1:0]      sample;
    logic        [IndexBits-1:0]       index;
    logic signed [CoefBits-1:0]        coef;
  } fir_word_t;

  // One output word as the filter should produce it.
  typedef struct {
    logic signed [SampleBits-1:0] sample;
    logic                         clipped;
  } fir_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;

  // Local copy of the filter state.
  logic signed [SampleBits-1:0] tap_line [Ntap];
  logic signed [CoefBits-1:0]   half_coefs [Half + 1];
  int                           tap_head;

  fir_result_t pending_results [$];
  fir_result_t oldest_result;
  int          mismatch_count;

  // Percentage of cycles in which the source holds back or the sink stalls.
  int src_idle_pct;
  int sink_stall_pct;

  symmetric_fir_with_bypass dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),   // sample_in, coef_index, coef_value, zero fill
    .s_axis_tuser  (s_axis_tuser),   // mode, bypass
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // sample_out, zero fill
    .m_axis_tuser  (m_axis_tuser),   // clipped
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk_i = ~clk_i;

  // The sink changes its mind at every falling edge, so stalls land on any
  // cycle of the filter's work, including the one where a result appears.
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic fir_word_t make_word(input logic mode, input logic bypass,
                                          input int sample, input int index,
                                          input int coef);
    fir_word_t w;
    w.mode   = mode;
    w.bypass = bypass;
    w.sample = sample[SampleBits-1:0];
    w.index  = index[IndexBits-1:0];
    w.coef   = coef[CoefBits-1:0];
    return w;
  endfunction

  // Mirror one accepted word into the local filter state. A filter word also
  // yields the expected output: the folded sum of products, rounded half up
  // and clamped to the sample range, or the middle sample when bypassed.
  task automatic apply_fir_word(input fir_word_t w);
    fir_result_t r;
    longint      acc;
    longint      pair_sum;
    if (w.mode == sfir_pkg::ModeLoad) begin
      // Indices beyond the centre tap do not exist and are dropped.
      if (int'(w.index) <= Half) begin
        half_coefs[w.index] = w.coef;
      end
      return;
    end
    tap_head = (tap_head == 0) ? Ntap - 1 : tap_head - 1;
    tap_line[tap_head] = w.sample;
    r.clipped = 1'b0;
    if (w.bypass) begin
      r.sample = tap_line[(tap_head + Half) % Ntap];
    end else begin
      // The exact sum stays well inside 64 bits for 24-bit operands.
      acc = longint'(half_coefs[Half]) * longint'(tap_line[(tap_head + Half) % Ntap]);
      for (int n = 0; n < Half; n++) begin
        pair_sum = longint'(tap_line[(tap_head + n) % Ntap]) +
                   longint'(tap_line[(tap_head + 2 * Half - n) % Ntap]);
        acc += longint'(half_coefs[n]) * pair_sum;
      end
      acc = (acc + (longint'(1) <<< (CoefBits - 2))) >>> (CoefBits - 1);
      if (acc > SatMax) begin
        acc = SatMax;
        r.clipped = 1'b1;
      end else if (acc < SatMin) begin
        acc = SatMin;
        r.clipped = 1'b1;
      end
      r.sample = acc[SampleBits-1:0];
    end
    pending_results.push_back(r);
  endtask

  // Present one word at a falling edge, after a random number of idle cycles,
  // and hold it until the filter takes it. The valid stays high on return so
  // that back-to-back words need no lowering in between.
  task automatic send_word(input fir_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  = {w.coef, w.index, w.sample};
    s_axis_tuser  = {w.bypass, w.mode};
    s_axis_tvalid = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    apply_fir_word(w);
  endtask

  function automatic int random_value(input int bits);
    int pick;
    int span;
    pick = $urandom_range(99);
    span = 1 << (bits - 1);
    if (pick < 40) begin
      return int'($urandom());
    end else if (pick < 65) begin
      return int'($urandom_range(2047)) - 1024;
    end else if (pick < 80) begin
      return int'($urandom_range(1 << 18)) - (1 << 17);
    end else begin
      case ($urandom_range(3))
        0:       return span - 1;
        1:       return -span;
        2:       return -1;
        default: return 0;
      endcase
    end
  endfunction

  // Mostly filter words, about a fifth of them bypassed, with coefficient
  // loads scattered in between. Every field carries random bits even where
  // the mode ignores it.
  function automatic fir_word_t random_word();
    fir_word_t w;
    w = make_word(($urandom_range(99) < 20) ? sfir_pkg::ModeLoad : sfir_pkg::ModeFilter,
                  $urandom_range(99) < 20, random_value(SampleBits),
                  ($urandom_range(99) < 90) ? $urandom_range(Half) :
                                              $urandom_range(255),
                  random_value(CoefBits));
    return w;
  endfunction

  // Dropped loads do not count towards the number of words sent.
  task automatic send_random_words(input int count);
    fir_word_t w;
    int        sent;
    sent = 0;
    while (sent < count) begin
      w = random_word();
      send_word(w);
      if (!(w.mode == sfir_pkg::ModeLoad && int'(w.index) > Half)) begin
        sent++;
      end
    end
  endtask

  // Directed cases on a freshly reset filter. With only the outermost pair
  // loaded, only the newest samples meet a coefficient, so each result can
  // be steered onto a rail or onto an exact half.
  task automatic test_directed_cases();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // Bypass with the delay line still empty, then filtering through an
    // all-zero table.
    send_word(make_word(sfir_pkg::ModeFilter, 1'b1, int'(SatMax), 0, 0));
    send_word(make_word(sfir_pkg::ModeFilter, 1'b0, int'(SatMin), 255, int'(SatMax)));
    // Loads to indices past the centre tap must leave the table alone.
    send_word(make_word(sfir_pkg::ModeLoad, 1'b0, 0, Half + 1, int'(SatMax)));
    send_word(make_word(sfir_pkg::ModeLoad, 1'b1, -1, 255, -1));
    send_word(make_word(sfir_pkg::ModeLoad, 1'b0, 0, Half, int'(SatMax)));
    send_word(make_word(sfir_pkg::ModeLoad, 1'b0, 0, 0, int'(SatMin)));
    // Minus one times minus one overflows to the upper rail.
    send_word(make_word(sfir_pkg::ModeFilter, 1'b0, int'(SatMin), 0, 0));
    send_word(make_word(sfir_pkg::ModeFilter, 1'b0, int'(SatMax), 0, 0));
    // Two pairs at minus one against two full-scale samples: lower rail.
    send_word(make_word(sfir_pkg::ModeLoad, 1'b0, 0, 1, int'(SatMin)));
    send_word(make_word(sfir_pkg::ModeFilter, 1'b0, int'(SatMax), 0, 0));
    // Half a least significant bit in either sign rounds towards plus
    // infinity.
    send_word(make_word(sfir_pkg::ModeLoad, 1'b0, 0, 0, 1 << (CoefBits - 2)));
    send_word(make_word(sfir_pkg::ModeLoad, 1'b0, 0, 1, 0));
    send_word(make_word(sfir_pkg::ModeFilter, 1'b0, 1, 0, 0));
    send_word(make_word(sfir_pkg::ModeFilter, 1'b0, -1, 0, 0));
    send_word(make_word(sfir_pkg::ModeFilter, 1'b0, 0, 0, 0));
    send_word(make_word(sfir_pkg::ModeFilter, 1'b1, -1, 0, 0));
  endtask

  task automatic test_no_idling();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_random_words(160);
  endtask

  task automatic test_source_gaps();
    src_idle_pct   = 73;
    sink_stall_pct = 0;
    send_random_words(160);
  endtask

  task automatic test_sink_stalls();
    src_idle_pct   = 0;
    sink_stall_pct = 73;
    send_random_words(160);
  endtask

  task automatic test_light_idling();
    src_idle_pct   = 6;
    sink_stall_pct = 6;
    send_random_words(160);
  endtask

  // Each output word taken by the sink is held against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("output word arrived with no result pending");
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tdata[SampleBits-1:0] !== oldest_result.sample) begin
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    $signed(m_axis_tdata[SampleBits-1:0]),
                                    oldest_result.sample));
        end
        if (m_axis_tuser[0] !== oldest_result.clipped) begin
          report_mismatch($sformatf("clipped %0b, expected %0b",
                                    m_axis_tuser[0], oldest_result.clipped));
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    s_axis_tvalid  = 1'b0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    mismatch_count = 0;
    tap_head       = 0;
    for (int i = 0; i < Ntap; i++) begin
      tap_line[i] = '0;
    end
    for (int i = 0; i <= Half; i++) begin
      half_coefs[i] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // The filter clears its memories after reset; the first word simply
    // waits for tready.
    test_directed_cases();
    test_no_idling();
    test_source_gaps();
    test_sink_stalls();
    test_light_idling();

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    // Give any stray result time to show up after the last expected one.
    repeat (2 * Ntap) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** symmetric_fir_with_bypass: PASSED **");
    end else begin
      $display("** symmetric_fir_with_bypass: FAILED **");
    end
    $finish;
  end

  // Roughly five times the longest plausible run.
  initial begin
    #10_000_000;
    $display("** symmetric_fir_with_bypass: FAILED **");
    $finish;
  end

endmodule
